### hw/rtl/pdr_pkg.sv
package pdr_pkg;

  // rotation steps of the sine/cosine unit, 8 .. 24
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int COR_CNT_W    = $clog2(CORDIC_ITERS);

  // start vector, inverse gain of the 24-step rotation in Q3.30
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  // 65536 / (2*pi) in Q16.16
  localparam logic signed [31:0] TURN_Q16 = 32'sd683565276;

  // serial multiplier: 32 x 32 signed, one 4-bit digit of the multiplier per cycle
  localparam int MUL_WIDTH = 32;
  localparam int MUL_DIGIT = 4;
  localparam int MUL_STEPS = MUL_WIDTH / MUL_DIGIT;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);
  localparam int MUL_HI_W  = MUL_WIDTH + 2;
  localparam int MUL_PP_W  = MUL_HI_W + MUL_DIGIT;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_WAIT,
    ST_MUL3,
    ST_UPDATE
  } pdr_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pdr_stat_t;

  // arctangent of 2^-i, 2^32 units per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/pdr_serial_mul.sv
module pdr_serial_mul (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  logic signed [pdr_pkg::MUL_WIDTH-1:0]     a,
  input  logic signed [pdr_pkg::MUL_WIDTH-1:0]     b,
  output pdr_pkg::pdr_stat_t                       stat,
  output logic signed [2*pdr_pkg::MUL_WIDTH-1:0]   p
);
  import pdr_pkg::*;

  logic                          busy;
  logic                          done;
  logic [MUL_CNT_W-1:0]          cnt;
  logic signed [MUL_WIDTH-1:0]   mcand;
  logic [MUL_WIDTH-1:0]          mplier;
  logic signed [MUL_HI_W-1:0]    hi;
  logic [MUL_WIDTH-1:0]          lo;
  logic                          last;
  logic signed [MUL_DIGIT:0]     dig;
  logic signed [MUL_PP_W-1:0]    pp;
  logic signed [MUL_PP_W-1:0]    sum;

  always_comb begin
    last = (cnt == MUL_CNT_W'(MUL_STEPS - 1));
    // top digit carries the sign of the multiplier
    dig  = last ? $signed({mplier[MUL_DIGIT-1], mplier[MUL_DIGIT-1:0]})
                : $signed({1'b0, mplier[MUL_DIGIT-1:0]});
    pp   = MUL_PP_W'(mcand) * MUL_PP_W'(dig);
    sum  = MUL_PP_W'(hi) + pp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      mcand  <= a;
      mplier <= b;
      hi     <= '0;
    end else if (busy) begin
      mplier <= mplier >> MUL_DIGIT;
      hi     <= sum[MUL_PP_W-1:MUL_DIGIT];
      lo     <= {sum[MUL_DIGIT-1:0], lo[MUL_WIDTH-1:MUL_DIGIT]};
    end
  end

  assign stat = '{busy: busy, done: done};
  assign p    = {hi[MUL_WIDTH-1:0], lo};

endmodule

### hw/rtl/pdr_cordic.sv
module pdr_cordic (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [15:0]         angle,
  output pdr_pkg::pdr_stat_t  stat,
  output logic signed [16:0]  cos_out,
  output logic signed [16:0]  sin_out
);
  import pdr_pkg::*;

  logic                  busy;
  logic                  fin;
  logic                  done;
  logic                  flip;
  logic [COR_CNT_W-1:0]  idx;
  logic signed [33:0]    x;
  logic signed [33:0]    y;
  logic signed [32:0]    z;
  logic signed [33:0]    xs;
  logic signed [33:0]    ys;
  logic signed [32:0]    at;
  logic signed [33:0]    xr;
  logic signed [33:0]    yr;

  always_comb begin
    xs = x >>> idx;
    ys = y >>> idx;
    at = $signed({1'b0, atan_turn(5'(idx))});
    // undo the half-turn fold, then round to q1.15
    xr = (flip ? -x : x) + 34'sd16384;
    yr = (flip ? -y : y) + 34'sd16384;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        fin  <= 1'b0;
        idx  <= '0;
      end else if (busy && !fin) begin
        idx <= idx + 1'b1;
        if (idx == COR_CNT_W'(CORDIC_ITERS - 1)) fin <= 1'b1;
      end else if (fin) begin
        busy <= 1'b0;
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      x    <= CORDIC_GAIN_Q30;
      y    <= '0;
      // left and right quadrants fold onto the front half
      flip <= angle[15] ^ angle[14];
      z    <= $signed({angle[14], angle[14], angle[14:0], 16'h0000});
    end else if (busy && !fin) begin
      if (!z[32]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end else if (fin) begin
      cos_out <= xr[31:15];
      sin_out <= yr[31:15];
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule

### hw/rtl/pose_dead_reckoning_unit.sv
// Dead-reckoning pose tracker. Each request carries speed (Q8.8 m/s), turn rate
// (Q4.12 rad/s) and elapsed time (Q0.16 s); the block moves x and y along the heading
// held before the request, then turns the heading, and returns one result with the
// saturated Q16.16 position and the heading in Q9.7 degrees. Pose starts at zero on
// reset. One request is worked on at a time, paced by the 4-bit serial multipliers,
// which make three passes of 8 digits (speed and turn times time, turn times the
// angle scale, distance times cosine and sine). The rotation unit for sine and cosine
// runs its 16 steps under the first two passes. A finished result sits in an output
// register so a new request can be taken while it waits; the next result is written
// only once that register is free.
module pose_dead_reckoning_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // linear_velocity, angular_velocity, time_step
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata    // pos_x, pos_y, heading_degrees
);
  import pdr_pkg::*;

  pdr_state_t state, state_next;

  logic signed [31:0]  x_acc;
  logic signed [31:0]  y_acc;
  logic [15:0]         heading;
  logic [15:0]         dth;
  logic [31:0]         out_x;
  logic [31:0]         out_y;
  logic [15:0]         out_deg;

  logic                cor_start;
  pdr_stat_t           cor_st;
  logic signed [16:0]  cos_val;
  logic signed [16:0]  sin_val;

  logic                mul_a_start;
  logic signed [31:0]  mul_a_a;
  logic signed [31:0]  mul_a_b;
  pdr_stat_t           mul_a_st;
  logic signed [63:0]  mul_a_p;
  logic                mul_b_start;
  logic signed [31:0]  mul_b_a;
  logic signed [31:0]  mul_b_b;
  pdr_stat_t           mul_b_st;
  logic signed [63:0]  mul_b_p;

  logic                load_dth;
  logic                upd;
  logic [16:0]         dth_sum;
  logic signed [27:0]  dx_r;
  logic signed [27:0]  dy_r;
  logic signed [33:0]  x_sum;
  logic signed [33:0]  y_sum;
  logic signed [31:0]  x_new;
  logic signed [31:0]  y_new;
  logic [15:0]         h_new;
  logic signed [21:0]  h45;
  logic signed [21:0]  deg_sum;

  pdr_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (heading),
    .stat    (cor_st),
    .cos_out (cos_val),
    .sin_out (sin_val)
  );

  pdr_serial_mul u_mul_a (
    .clk   (clk),
    .rst   (rst),
    .start (mul_a_start),
    .a     (mul_a_a),
    .b     (mul_a_b),
    .stat  (mul_a_st),
    .p     (mul_a_p)
  );

  pdr_serial_mul u_mul_b (
    .clk   (clk),
    .rst   (rst),
    .start (mul_b_start),
    .a     (mul_b_a),
    .b     (mul_b_b),
    .stat  (mul_b_st),
    .p     (mul_b_p)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cor_start   = 1'b0;
    mul_a_start = 1'b0;
    mul_b_start = 1'b0;
    mul_a_a     = 32'(signed'(s_tdata[15:0]));
    mul_a_b     = $signed({16'h0000, s_tdata[47:32]});
    mul_b_a     = 32'(signed'(s_tdata[31:16]));
    mul_b_b     = $signed({16'h0000, s_tdata[47:32]});
    load_dth    = 1'b0;
    upd         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cor_start   = 1'b1;
          mul_a_start = 1'b1;
          mul_b_start = 1'b1;
          state_next  = ST_MUL1;
        end
      end
      ST_MUL1: begin
        // w*dt times the angle scale
        mul_b_a = mul_b_p[31:0];
        mul_b_b = TURN_Q16;
        if (mul_b_st.done) begin
          mul_b_start = 1'b1;
          state_next  = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (mul_b_st.done) begin
          load_dth   = 1'b1;
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        mul_a_a = mul_a_p[31:0];
        mul_a_b = 32'(cos_val);
        mul_b_a = mul_a_p[31:0];
        mul_b_b = 32'(sin_val);
        if (!cor_st.busy) begin
          mul_a_start = 1'b1;
          mul_b_start = 1'b1;
          state_next  = ST_MUL3;
        end
      end
      ST_MUL3: begin
        if (mul_a_st.done) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!m_tvalid || m_tready) begin
          upd        = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    // round half up at bit 44 of the scaled turn, keep 16 bits
    dth_sum = mul_b_p[59:43] + 17'd1;
    // round half up at bit 23 of the distance products
    dx_r    = 28'($signed(mul_a_p[48:22])) + 28'sd1;
    dy_r    = 28'($signed(mul_b_p[48:22])) + 28'sd1;
    x_sum   = 34'(x_acc) + 34'($signed(dx_r[27:1]));
    y_sum   = 34'(y_acc) + 34'($signed(dy_r[27:1]));
    if (x_sum[33:31] == 3'b000 || x_sum[33:31] == 3'b111) x_new = x_sum[31:0];
    else x_new = x_sum[33] ? 32'sh80000000 : 32'sh7fffffff;
    if (y_sum[33:31] == 3'b000 || y_sum[33:31] == 3'b111) y_new = y_sum[31:0];
    else y_new = y_sum[33] ? 32'sh80000000 : 32'sh7fffffff;
    h_new   = heading + dth;
    // 360 * 128 / 65536 = 45 / 64
    h45     = 22'(signed'(h_new)) * 22'sd45;
    deg_sum = h45 + 22'sd32;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_acc    <= '0;
      y_acc    <= '0;
      heading  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      if (upd) begin
        x_acc    <= x_new;
        y_acc    <= y_new;
        heading  <= h_new;
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_dth) dth <= dth_sum[16:1];
    if (upd) begin
      out_x   <= x_new;
      out_y   <= y_new;
      out_deg <= deg_sum[21:6];
    end
  end

  assign m_tdata = {out_deg, out_y, out_x};

  a_accept_starts_cordic: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> cor_st.busy)
    else $error("rotation unit not started on accepted request");

  a_idle_units_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cor_st.busy && !mul_a_st.busy && !mul_b_st.busy)
    else $error("arithmetic unit busy while taking a request");

  a_first_pass_aligned: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL1 && mul_b_st.done |-> mul_a_st.done)
    else $error("first multiply passes out of step");

  a_cos_ready: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL3 |-> !cor_st.busy)
    else $error("distance multiply started before sine and cosine");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    upd |=> m_tvalid && $past(!m_tvalid || m_tready))
    else $error("result overwritten before it was taken");

endmodule
